// ===== src/rtc_ltr_pkg.sv =====
// rtc_ltr_pkg: shared types, command and register codes, small divide helpers
// for the latched real-time clock. No dependencies.
package rtc_ltr_pkg;

	// command codes
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_LATCH = 2'd3;

	// register indexes
	localparam logic [2:0] REG_SEC      = 3'd0;
	localparam logic [2:0] REG_MIN      = 3'd1;
	localparam logic [2:0] REG_HOUR     = 3'd2;
	localparam logic [2:0] REG_DAY_LOW  = 3'd3;
	localparam logic [2:0] REG_DAY_HIGH = 3'd4;

	localparam int NUM_REGS = 5;

	// day high bit positions
	localparam int DH_DAY8_BIT  = 0;
	localparam int DH_HALT_BIT  = 6;
	localparam int DH_CARRY_BIT = 7;

	// one register beat held in the input stage
	typedef struct packed {
		logic [1:0] cmd;
		logic [2:0] reg_sel;
		logic [7:0] write_data;
	} op_t;

	// time in register form, always normalized
	typedef struct packed {
		logic [5:0] secs;
		logic [5:0] mins;
		logic [4:0] hours;
		logic [8:0] day;
		logic       halt;
		logic       carry;
	} view_t;

	// byte / 60, quotient 0..4
	function automatic logic [2:0] quo60(input logic [7:0] d);
		quo60 = 3'(d >= 8'd60) + 3'(d >= 8'd120) + 3'(d >= 8'd180) + 3'(d >= 8'd240);
	endfunction

	function automatic logic [5:0] rem60(input logic [7:0] d);
		logic [7:0] q;
		q = 8'(quo60(d));
		rem60 = 6'(d - 8'(q * 8'd60));
	endfunction

	// byte / 24, quotient 0..10
	function automatic logic [3:0] quo24(input logic [7:0] d);
		logic [3:0] q;
		q = '0;
		for (int k = 1; k <= 10; k++) begin
			q = q + 4'(d >= 8'(24 * k));
		end
		quo24 = q;
	endfunction

	function automatic logic [4:0] rem24(input logic [7:0] d);
		logic [7:0] q;
		q = 8'(quo24(d));
		rem24 = 5'(d - 8'(q * 8'd24));
	endfunction

	// byte form of one register of the split view
	function automatic logic [7:0] view_byte(input view_t v, input logic [2:0] idx);
		logic [7:0] b;
		b = '0;
		unique case (idx)
			REG_SEC:      b = 8'(v.secs);
			REG_MIN:      b = 8'(v.mins);
			REG_HOUR:     b = 8'(v.hours);
			REG_DAY_LOW:  b = v.day[7:0];
			REG_DAY_HIGH: begin
				b[DH_DAY8_BIT]  = v.day[8];
				b[DH_HALT_BIT]  = v.halt;
				b[DH_CARRY_BIT] = v.carry;
			end
			default:      b = '0;
		endcase
		view_byte = b;
	endfunction

endpackage

// ===== src/rtc_ltr_clock.sv =====
// rtc_ltr_clock: time-keeping registers held as seconds/minutes/hours/day,
// tick and register-write update with carry ripple. Uses rtc_ltr_pkg.
module rtc_ltr_clock (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  rtc_ltr_pkg::op_t  op,
	output rtc_ltr_pkg::view_t view
);

	logic [5:0] secs_q, mins_q;
	logic [4:0] hours_q;
	logic [8:0] day_q;
	logic       halt_q, carry_q;

	logic [5:0] secs_n, mins_in, mins_n;
	logic [4:0] hours_in, hours_n;
	logic [8:0] day_in;
	logic [2:0] mins_add, hours_add;
	logic [3:0] day_add;
	logic       halt_n, carry_base;
	logic [6:0] secs_sum, mins_sum;
	logic [5:0] hours_sum;
	logic [9:0] day_sum;
	logic       c_min, c_hour, wrap;
	logic       is_wr;

	assign is_wr = (op.cmd == rtc_ltr_pkg::CMD_WRITE);

	// pick field inputs and carry-ins per command
	always_comb begin
		secs_n     = secs_q;
		mins_in    = mins_q;
		hours_in   = hours_q;
		day_in     = day_q;
		mins_add   = '0;
		hours_add  = '0;
		day_add    = '0;
		halt_n     = halt_q;
		carry_base = carry_q;
		secs_sum   = 7'(secs_q) + 7'd1;
		if (op.cmd == rtc_ltr_pkg::CMD_TICK && !halt_q) begin
			if (secs_sum >= 7'd60) begin
				secs_n   = '0;
				mins_add = 3'd1;
			end else begin
				secs_n = 6'(secs_sum);
			end
		end else if (is_wr) begin
			unique case (op.reg_sel)
				rtc_ltr_pkg::REG_SEC: begin
					secs_n   = rtc_ltr_pkg::rem60(op.write_data);
					mins_add = rtc_ltr_pkg::quo60(op.write_data);
				end
				rtc_ltr_pkg::REG_MIN: begin
					mins_in   = rtc_ltr_pkg::rem60(op.write_data);
					hours_add = rtc_ltr_pkg::quo60(op.write_data);
				end
				rtc_ltr_pkg::REG_HOUR: begin
					hours_in = rtc_ltr_pkg::rem24(op.write_data);
					day_add  = rtc_ltr_pkg::quo24(op.write_data);
				end
				rtc_ltr_pkg::REG_DAY_LOW: begin
					day_in = {day_q[8], op.write_data};
				end
				rtc_ltr_pkg::REG_DAY_HIGH: begin
					day_in     = {op.write_data[rtc_ltr_pkg::DH_DAY8_BIT], day_q[7:0]};
					halt_n     = op.write_data[rtc_ltr_pkg::DH_HALT_BIT];
					carry_base = op.write_data[rtc_ltr_pkg::DH_CARRY_BIT];
				end
				default: begin
				end
			endcase
		end
	end

	// carry ripple minutes -> hours -> days, wrap at 512 days
	always_comb begin
		mins_sum  = 7'(mins_in) + 7'(mins_add);
		c_min     = (mins_sum >= 7'd60);
		mins_n    = c_min ? 6'(mins_sum - 7'd60) : 6'(mins_sum);
		hours_sum = 6'(hours_in) + 6'(hours_add) + 6'(c_min);
		c_hour    = (hours_sum >= 6'd24);
		hours_n   = c_hour ? 5'(hours_sum - 6'd24) : 5'(hours_sum);
		day_sum   = 10'(day_in) + 10'(day_add) + 10'(c_hour);
		wrap      = day_sum[9];
	end

	// time state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secs_q  <= '0;
			mins_q  <= '0;
			hours_q <= '0;
			day_q   <= '0;
			halt_q  <= 1'b0;
			carry_q <= 1'b0;
		end else if (en) begin
			secs_q  <= secs_n;
			mins_q  <= mins_n;
			hours_q <= hours_n;
			day_q   <= day_sum[8:0];
			halt_q  <= halt_n;
			carry_q <= carry_base | wrap;
		end
	end

	always_comb begin
		view.secs  = secs_q;
		view.mins  = mins_q;
		view.hours = hours_q;
		view.day   = day_q;
		view.halt  = halt_q;
		view.carry = carry_q;
	end

endmodule

// ===== src/rtc_latched_time_registers.sv =====
// rtc_latched_time_registers: top level with input stage, latched shadow
// registers and result register. Uses rtc_ltr_pkg and rtc_ltr_clock.
//
// Real-time clock with seconds, minutes, hours, day low and day high byte
// registers, counting up to 512 days with sticky carry and halt. Every beat
// (tick, write, read, latch) returns exactly one result beat: the latched byte
// on a read, zero otherwise. One beat is taken per clock while not stalled; a
// beat lands in the input stage, acts on the clock and shadow registers when
// it advances, then offers its result from the result register. It advances
// while the result register is empty or its result is taken; a stall holds
// both stages. Writes normalize out-of-range bytes by carrying into the higher
// fields and set carry on a 512-day wrap; writes apply while halted.
module rtc_latched_time_registers (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [2:0] reg_sel,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data
);

	rtc_ltr_pkg::op_t   op_s1;
	logic               vld_s1;
	logic               adv_s1;
	rtc_ltr_pkg::view_t view;
	logic [7:0]         latch_q [rtc_ltr_pkg::NUM_REGS];
	logic [7:0]         rd_byte;
	logic [7:0]         read_data_q;
	logic               out_vld_q;

	// stage handshake
	assign adv_s1   = vld_s1 && (!out_vld_q || !out_stall);
	assign in_stall = vld_s1 && !adv_s1;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1.cmd        <= cmd;
			op_s1.reg_sel    <= reg_sel;
			op_s1.write_data <= write_data;
		end
	end

	// clock state
	rtc_ltr_clock u_clock (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s1),
		.op     (op_s1),
		.view   (view)
	);

	// shadow registers, loaded on latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rtc_ltr_pkg::NUM_REGS; i++) begin
				latch_q[i] <= '0;
			end
		end else if (adv_s1 && op_s1.cmd == rtc_ltr_pkg::CMD_LATCH) begin
			for (int i = 0; i < rtc_ltr_pkg::NUM_REGS; i++) begin
				latch_q[i] <= rtc_ltr_pkg::view_byte(view, 3'(i));
			end
		end
	end

	// read mux, zero for other commands and bad indexes
	always_comb begin
		rd_byte = '0;
		if (op_s1.cmd == rtc_ltr_pkg::CMD_READ) begin
			unique case (op_s1.reg_sel)
				rtc_ltr_pkg::REG_SEC:      rd_byte = latch_q[0];
				rtc_ltr_pkg::REG_MIN:      rd_byte = latch_q[1];
				rtc_ltr_pkg::REG_HOUR:     rd_byte = latch_q[2];
				rtc_ltr_pkg::REG_DAY_LOW:  rd_byte = latch_q[3];
				rtc_ltr_pkg::REG_DAY_HIGH: rd_byte = latch_q[4];
				default:                   rd_byte = '0;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			read_data_q <= rd_byte;
		end
	end

	assign out_valid = out_vld_q;
	assign read_data = read_data_q;

endmodule
